@@ rtl/core/v3n_pkg.sv @@
// ----------------------------------------------------------------------------
// v3n_pkg: shared types and constants for vector3_normalize
// Item structs and the records carried down the square-root and divide cells.
// ----------------------------------------------------------------------------
`default_nettype none

package v3n_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int NUM_LANES   = 3;
    localparam int SUM_WIDTH   = 2 * COORD_WIDTH;
    localparam int ROOT_STEPS  = COORD_WIDTH;          // one root bit per cell
    localparam int REM_WIDTH   = COORD_WIDTH + 2;      // square-root remainder
    localparam int FRAC_OUT    = 30;
    localparam int QUO_WIDTH   = FRAC_OUT + 1;         // quotient <= 2^30
    localparam int DIV_STEPS   = QUO_WIDTH;            // one quotient bit per cell
    localparam int DREM_WIDTH  = COORD_WIDTH + 1;      // divide partial remainder

    typedef struct packed {
        logic signed [31:0] coord_x;
        logic signed [31:0] coord_y;
        logic signed [31:0] coord_z;
    } v3n_in_t;

    typedef struct packed {
        logic signed [31:0] unit_x;
        logic signed [31:0] unit_y;
        logic signed [31:0] unit_z;
        logic        [31:0] magnitude;
        logic               zero_length;
    } v3n_out_t;

    typedef struct packed {
        logic                                    valid;
        logic [SUM_WIDTH-1:0]                    rad;
        logic [REM_WIDTH-1:0]                    rem;
        logic [COORD_WIDTH-1:0]                  root;
        logic [NUM_LANES-1:0][COORD_WIDTH-1:0]   abs_val;
        logic [NUM_LANES-1:0]                    neg;
    } v3n_sq_t;

    typedef struct packed {
        logic                                    valid;
        logic [COORD_WIDTH-1:0]                  len;
        logic [NUM_LANES-1:0][DREM_WIDTH-1:0]    rem;
        logic [NUM_LANES-1:0][QUO_WIDTH-1:0]     quo;
        logic [NUM_LANES-1:0]                    neg;
    } v3n_dv_t;

endpackage

`default_nettype wire

@@ rtl/core/v3n_sqrt_cell.sv @@
// ----------------------------------------------------------------------------
// v3n_sqrt_cell: one digit of the floor square root
// Takes two radicand bits, decides one root bit, registers the record.
// ----------------------------------------------------------------------------
`default_nettype none

module v3n_sqrt_cell (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             adv,
    input  wire v3n_pkg::v3n_sq_t cell_in,
    output v3n_pkg::v3n_sq_t      cell_out
);
    import v3n_pkg::*;

    logic [REM_WIDTH+1:0] acc;
    logic [REM_WIDTH+1:0] trial;
    logic                 fits;
    v3n_sq_t              rec_next;
    v3n_sq_t              rec_reg;

    always_comb
    begin
        acc      = {cell_in.rem, cell_in.rad[SUM_WIDTH-1 -: 2]};
        trial    = {{(REM_WIDTH-COORD_WIDTH){1'b0}}, cell_in.root, 2'b01};
        fits     = (acc >= trial);
        rec_next = cell_in;
        rec_next.rad = {cell_in.rad[SUM_WIDTH-3:0], 2'b00};
        if (fits)
        begin
            rec_next.rem  = REM_WIDTH'(acc - trial);
            rec_next.root = {cell_in.root[COORD_WIDTH-2:0], 1'b1};
        end
        else
        begin
            rec_next.rem  = REM_WIDTH'(acc);
            rec_next.root = {cell_in.root[COORD_WIDTH-2:0], 1'b0};
        end
    end

    // only the valid bit is reset; data simply holds
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rec_reg.valid <= 1'b0;
        end
        else if (adv)
        begin
            rec_reg <= rec_next;
        end
    end

    assign cell_out = rec_reg;

endmodule

`default_nettype wire

@@ rtl/core/v3n_div_cell.sv @@
// ----------------------------------------------------------------------------
// v3n_div_cell: one restoring-divide step for all three lanes
// Compare with the length, subtract if it fits, shift, record one quotient bit.
// ----------------------------------------------------------------------------
`default_nettype none

module v3n_div_cell (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             adv,
    input  wire v3n_pkg::v3n_dv_t cell_in,
    output v3n_pkg::v3n_dv_t      cell_out
);
    import v3n_pkg::*;

    logic [DREM_WIDTH-1:0] len_ext;
    logic [DREM_WIDTH-1:0] diff [NUM_LANES];
    logic [NUM_LANES-1:0]  fits;
    v3n_dv_t               rec_next;
    v3n_dv_t               rec_reg;

    always_comb
    begin
        len_ext  = {1'b0, cell_in.len};
        rec_next = cell_in;
        for (int j = 0; j < NUM_LANES; j++)
        begin
            fits[j] = (cell_in.rem[j] >= len_ext);
            diff[j] = fits[j] ? (cell_in.rem[j] - len_ext) : cell_in.rem[j];
            // remainder is below the length here, so one bit of headroom holds the shift
            rec_next.rem[j] = {diff[j][COORD_WIDTH-1:0], 1'b0};
            rec_next.quo[j] = {cell_in.quo[j][QUO_WIDTH-2:0], fits[j]};
        end
    end

    // only the valid bit is reset; data simply holds
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rec_reg.valid <= 1'b0;
        end
        else if (adv)
        begin
            rec_reg <= rec_next;
        end
    end

    assign cell_out = rec_reg;

endmodule

`default_nettype wire

@@ rtl/core/vector3_normalize.sv @@
// ----------------------------------------------------------------------------
// vector3_normalize: length and unit direction of a Q16.16 3D vector
// Squares, a chain of square-root cells and a chain of divide cells.
// ----------------------------------------------------------------------------
// Usage:
//   vec_* is the input channel: one item is one vector (coord_x, coord_y,
//   coord_z), signed Q16.16. res_* is the output channel: unit_x/y/z in
//   signed Q2.30 (truncated toward zero), magnitude in unsigned Q16.16 and
//   zero_length. Both use valid/stall; an item moves when valid && !stall.
//   Throughput: one item per cycle, sustained, as long as res_stall is low.
//   The path from acceptance to res_valid registers capture, square, sum,
//   32 square-root cells, divide setup, 31 divide cells, output register.
//   The whole pipe moves on one advance enable. When the receiver stalls
//   with a result waiting, the pipe freezes and vec_stall goes high in the
//   same cycle; no item is dropped or duplicated. Bubbles ride along as
//   invalid cells.
//   Reset clears every valid bit; the pipe is empty and takes an item at
//   once after reset. Items are independent; nothing is kept between them.
//   A 2D vector is sent with coord_z = 0.
// ----------------------------------------------------------------------------
`default_nettype none

module vector3_normalize (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              vec_valid,
    output logic                   vec_stall,
    input  wire v3n_pkg::v3n_in_t  vec_item,
    output logic                   res_valid,
    input  wire logic              res_stall,
    output v3n_pkg::v3n_out_t      res_item
);
    import v3n_pkg::*;

    // global advance: hold everything while a result waits on a stalled receiver
    logic adv;

    // stage A: capture, sign/magnitude split
    logic [COORD_WIDTH-1:0]                  raw [NUM_LANES];
    logic                                    a_valid_reg;
    logic [NUM_LANES-1:0][COORD_WIDTH-1:0]   a_abs_reg, a_abs_next;
    logic [NUM_LANES-1:0]                    a_neg_reg, a_neg_next;

    // stage B: exact squares
    logic                                    b_valid_reg;
    logic [NUM_LANES-1:0][SUM_WIDTH-1:0]     b_sq_reg;
    logic [NUM_LANES-1:0][COORD_WIDTH-1:0]   b_abs_reg;
    logic [NUM_LANES-1:0]                    b_neg_reg;

    // stage C: sum of squares (at most 3 * 2^62, fits 64 bits)
    logic                                    c_valid_reg;
    logic [SUM_WIDTH-1:0]                    c_sum_reg, c_sum_next;
    logic [NUM_LANES-1:0][COORD_WIDTH-1:0]   c_abs_reg;
    logic [NUM_LANES-1:0]                    c_neg_reg;

    v3n_sq_t sq_chain [ROOT_STEPS+1];
    v3n_dv_t dv_chain [DIV_STEPS+1];
    v3n_dv_t dv_setup_next;
    v3n_dv_t dv_setup_reg;

    logic                                    res_valid_reg;
    v3n_out_t                                res_item_reg, res_item_next;
    logic [COORD_WIDTH-1:0]                  len_last;
    logic [COORD_WIDTH-1:0]                  mag_q;

    assign adv       = !(res_valid_reg && res_stall);
    assign vec_stall = !adv;

    assign raw[0] = vec_item.coord_x[COORD_WIDTH-1:0];
    assign raw[1] = vec_item.coord_y[COORD_WIDTH-1:0];
    assign raw[2] = vec_item.coord_z[COORD_WIDTH-1:0];

    always_comb
    begin
        for (int j = 0; j < NUM_LANES; j++)
        begin
            a_neg_next[j] = raw[j][COORD_WIDTH-1];
            // most negative value maps to 2^(W-1), still fits unsigned W bits
            a_abs_next[j] = a_neg_next[j] ? (~raw[j] + 1'b1) : raw[j];
        end
    end

    always_comb
    begin
        c_sum_next = b_sq_reg[0] + b_sq_reg[1] + b_sq_reg[2];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg <= vec_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_abs_reg <= a_abs_next;
            a_neg_reg <= a_neg_next;
            for (int j = 0; j < NUM_LANES; j++)
            begin
                b_sq_reg[j] <= SUM_WIDTH'(a_abs_reg[j]) * SUM_WIDTH'(a_abs_reg[j]);
            end
            b_abs_reg <= a_abs_reg;
            b_neg_reg <= a_neg_reg;
            c_sum_reg <= c_sum_next;
            c_abs_reg <= b_abs_reg;
            c_neg_reg <= b_neg_reg;
        end
    end

    // square-root chain: one root bit per cell, MSB first
    always_comb
    begin
        sq_chain[0].valid   = c_valid_reg;
        sq_chain[0].rad     = c_sum_reg;
        sq_chain[0].rem     = '0;
        sq_chain[0].root    = '0;
        sq_chain[0].abs_val = c_abs_reg;
        sq_chain[0].neg     = c_neg_reg;
    end

    for (genvar k = 0; k < ROOT_STEPS; k++)
    begin : g_sqrt
        v3n_sqrt_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .adv      (adv),
            .cell_in  (sq_chain[k]),
            .cell_out (sq_chain[k+1])
        );
    end

    // divide setup: partial remainder starts at |coord| (never above the length)
    always_comb
    begin
        dv_setup_next.valid = sq_chain[ROOT_STEPS].valid;
        dv_setup_next.len   = sq_chain[ROOT_STEPS].root;
        dv_setup_next.neg   = sq_chain[ROOT_STEPS].neg;
        for (int j = 0; j < NUM_LANES; j++)
        begin
            dv_setup_next.rem[j] = {1'b0, sq_chain[ROOT_STEPS].abs_val[j]};
            dv_setup_next.quo[j] = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_setup_reg.valid <= 1'b0;
        end
        else if (adv)
        begin
            dv_setup_reg <= dv_setup_next;
        end
    end

    assign dv_chain[0] = dv_setup_reg;

    // divide chain: quotient bit 30 (integer) first, then 30 fraction bits
    for (genvar k = 0; k < DIV_STEPS; k++)
    begin : g_div
        v3n_div_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .adv      (adv),
            .cell_in  (dv_chain[k]),
            .cell_out (dv_chain[k+1])
        );
    end

    // output formatting: apply sign, force zeros for a zero-length vector
    assign len_last = dv_chain[DIV_STEPS].len;
    assign mag_q    = len_last;

    always_comb
    begin
        logic [NUM_LANES-1:0][31:0] unit;
        logic                       zero;
        zero = (len_last == '0);
        for (int j = 0; j < NUM_LANES; j++)
        begin
            unit[j] = 32'(dv_chain[DIV_STEPS].quo[j]);
            if (dv_chain[DIV_STEPS].neg[j])
            begin
                unit[j] = ~unit[j] + 32'd1;
            end
            if (zero)
            begin
                unit[j] = '0;
            end
        end
        res_item_next.unit_x      = unit[0];
        res_item_next.unit_y      = unit[1];
        res_item_next.unit_z      = unit[2];
        res_item_next.magnitude   = 32'(mag_q);
        res_item_next.zero_length = zero;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            res_valid_reg <= dv_chain[DIV_STEPS].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            res_item_reg <= res_item_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_item  = res_item_reg;

endmodule

`default_nettype wire
